[hw/rtl/lowest_free_slot_allocator_top_defines.svh]
// Assertion macros shared by the lowest free slot allocator RTL.
`ifndef LOWEST_FREE_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define LOWEST_FREE_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LFSA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);
`define LFSA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LFSA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define LFSA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

[hw/rtl/lfsa_pkg.sv]
// Package with widths, codes and types of the lowest free slot allocator.
`default_nettype none
package lfsa_pkg;

  localparam int ACTION_W   = 2;
  localparam int INTERVAL_W = 8;
  localparam int SLOT_W     = 7;
  localparam int COUNT_W    = 9;
  localparam int OUTCOME_W  = 3;
  localparam int CFG_W      = 7;

  localparam int MAX_SLOTS_DEF     = 64;
  localparam int MAX_INTERVALS_DEF = 256;

  localparam logic [CFG_W-1:0]   SLOTS_IN_USE_RST = 7'd64;
  localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;

  localparam logic [ACTION_W-1:0] ACT_EVENT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_ALLOCATED  = 3'd0,
    OUT_OVERFLOWED = 3'd1,
    OUT_RELEASED   = 3'd2,
    OUT_QUERY      = 3'd3,
    OUT_CLEARED    = 3'd4
  } outcome_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EV_RD,
    ST_EV_DEC,
    ST_SCAN,
    ST_ALLOC_WR,
    ST_Q_RD,
    ST_Q_ACC,
    ST_RESULT
  } state_t;

endpackage
`default_nettype wire

[hw/rtl/lfsa_if.sv]
// Handshake interfaces for the request, result and configuration channels.
`default_nettype none
interface lfsa_in_if;
  import lfsa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [ACTION_W-1:0]   action;
  logic [INTERVAL_W-1:0] interval_id;
  logic [SLOT_W-1:0]     slot_limit;
  modport source (output valid, output action, output interval_id, output slot_limit,
                  input ready);
  modport sink (input valid, input action, input interval_id, input slot_limit,
                output ready);
endinterface

interface lfsa_out_if;
  import lfsa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic [SLOT_W-1:0]    slot;
  logic [COUNT_W-1:0]   served_count;
  modport source (output valid, output outcome, output slot, output served_count,
                  input ready);
  modport sink (input valid, input outcome, input slot, input served_count,
                output ready);
endinterface

interface lfsa_cfg_if;
  import lfsa_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/lowest_free_slot_allocator_top.sv]
// Lowest free slot allocator: sequencer, slot scan, held-slot and usage memories.
// An event releases the slot its interval holds, else scans for the lowest free slot below
// the limit and allocates it or reports an overflow; a query sums the usage counters below
// its limit and a clear reruns the clearing pass. Requests are taken only in the idle state.
// The slot scan tests one free bit per cycle; the query reads and adds one usage counter
// at a time. After reset a clearing pass runs over max(MAX_INTERVALS, MAX_SLOTS) entries.
`default_nettype none
`include "lowest_free_slot_allocator_top_defines.svh"
module lowest_free_slot_allocator_top #(
  parameter int MAX_SLOTS     = lfsa_pkg::MAX_SLOTS_DEF,
  parameter int MAX_INTERVALS = lfsa_pkg::MAX_INTERVALS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lfsa_in_if.sink    in_req,
  lfsa_out_if.source out_res,
  lfsa_cfg_if.sink   cfg_wr
);
  import lfsa_pkg::*;

  localparam int SW    = $clog2(MAX_SLOTS + 2);
  localparam int SIW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int IW    = $clog2(MAX_INTERVALS);
  localparam int CLR_N = (MAX_INTERVALS > MAX_SLOTS) ? MAX_INTERVALS : MAX_SLOTS;
  localparam int CW    = $clog2(CLR_N);
  localparam int IDN   = 1 << INTERVAL_W;

  localparam logic [SW-1:0] OVF_MARK    = SW'(MAX_SLOTS + 1);
  localparam logic [SW-1:0] MAX_SLOTS_S = SW'(MAX_SLOTS);
  localparam logic [CW-1:0] CLR_LAST    = CW'(CLR_N - 1);

  state_t               state_r, state_nxt;
  logic [CFG_W-1:0]     slots_in_use_r, slots_in_use_nxt;
  logic [MAX_SLOTS-1:0] free_r, free_nxt;
  logic [IW-1:0]        id_r, id_nxt;
  logic [SW-1:0]        scan_r, scan_nxt;
  logic [SW-1:0]        lim_r, lim_nxt;
  logic [COUNT_W-1:0]   sum_r, sum_nxt;
  logic [CW-1:0]        clr_r, clr_nxt;
  logic                 clr_report_r, clr_report_nxt;
  outcome_t             res_outcome_r, res_outcome_nxt;
  logic [SW-1:0]        res_slot_r, res_slot_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUTCOME_W-1:0] out_outcome_r, out_outcome_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;

  logic [SW-1:0]        held_mem [MAX_INTERVALS];
  logic [SW-1:0]        held_rd_r;
  logic                 held_we;
  logic [IW-1:0]        held_waddr;
  logic [SW-1:0]        held_wdata;
  logic [COUNT_W-1:0]   usage_mem [MAX_SLOTS];
  logic [COUNT_W-1:0]   usage_rd_r;
  logic                 usage_we;
  logic [SIW-1:0]       usage_waddr;
  logic [COUNT_W-1:0]   usage_wdata;

  logic [IW-1:0]        id_tab [IDN];
  logic [SW-1:0]        limit;
  logic [SW-1:0]        qlim;
  logic                 in_acc;
  logic                 scan_done;
  logic                 scan_hit;
  logic                 q_last;
  logic                 out_free;
  logic [COUNT_W:0]     sum_wide;

  for (genvar g = 0; g < IDN; g++) begin : g_id_tab
    assign id_tab[g] = IW'(g % MAX_INTERVALS);
  end

  assign in_acc    = in_req.valid && in_req.ready;
  assign limit     = (int'(slots_in_use_r) > MAX_SLOTS) ? MAX_SLOTS_S : SW'(slots_in_use_r);
  assign qlim      = (int'(in_req.slot_limit) > MAX_SLOTS) ? MAX_SLOTS_S
                                                            : SW'(in_req.slot_limit);
  assign scan_done = (scan_r >= limit);
  assign scan_hit  = free_r[scan_r[SIW-1:0]];
  assign q_last    = (({1'b0, scan_r} + (SW + 1)'(1)) >= {1'b0, lim_r});
  assign out_free  = !out_valid_r || out_res.ready;
  assign sum_wide  = {1'b0, sum_r} + {1'b0, usage_rd_r};

  assign in_req.ready         = (state_r == ST_IDLE);
  assign cfg_wr.ready         = (state_r == ST_IDLE) || (state_r == ST_CLEAR);
  assign out_res.valid        = out_valid_r;
  assign out_res.outcome      = out_outcome_r;
  assign out_res.slot         = out_slot_r;
  assign out_res.served_count = out_count_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == CLR_LAST) begin
          state_nxt = clr_report_r ? ST_RESULT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_req.action)
            ACT_EVENT: state_nxt = ST_EV_RD;
            ACT_QUERY: state_nxt = (qlim == '0) ? ST_RESULT : ST_Q_RD;
            ACT_CLEAR: state_nxt = ST_CLEAR;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_EV_RD:    state_nxt = ST_EV_DEC;
      ST_EV_DEC:   state_nxt = (held_rd_r == '0) ? ST_SCAN : ST_RESULT;
      ST_SCAN: begin
        priority if (scan_done) begin
          state_nxt = ST_RESULT;
        end else if (scan_hit) begin
          state_nxt = ST_ALLOC_WR;
        end
      end
      ST_ALLOC_WR: state_nxt = ST_RESULT;
      ST_Q_RD:     state_nxt = ST_Q_ACC;
      ST_Q_ACC:    state_nxt = q_last ? ST_RESULT : ST_Q_RD;
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    slots_in_use_nxt = slots_in_use_r;
    free_nxt         = free_r;
    id_nxt           = id_r;
    scan_nxt         = scan_r;
    lim_nxt          = lim_r;
    sum_nxt          = sum_r;
    clr_nxt          = clr_r;
    clr_report_nxt   = clr_report_r;
    res_outcome_nxt  = res_outcome_r;
    res_slot_nxt     = res_slot_r;
    out_valid_nxt    = out_valid_r && !out_res.ready;
    out_outcome_nxt  = out_outcome_r;
    out_slot_nxt     = out_slot_r;
    out_count_nxt    = out_count_r;
    held_we          = 1'b0;
    held_waddr       = id_r;
    held_wdata       = '0;
    usage_we         = 1'b0;
    usage_waddr      = scan_r[SIW-1:0];
    usage_wdata      = '0;

    if (cfg_wr.valid && cfg_wr.ready) begin
      slots_in_use_nxt = cfg_wr.data;
    end

    unique case (state_r)
      ST_CLEAR: begin
        held_we     = (int'(clr_r) < MAX_INTERVALS);
        held_waddr  = clr_r[IW-1:0];
        usage_we    = (int'(clr_r) < MAX_SLOTS);
        usage_waddr = clr_r[SIW-1:0];
        clr_nxt     = clr_r + CW'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          id_nxt       = id_tab[in_req.interval_id];
          scan_nxt     = '0;
          lim_nxt      = qlim;
          sum_nxt      = '0;
          res_slot_nxt = '0;
          unique case (in_req.action)
            ACT_EVENT: res_outcome_nxt = OUT_RELEASED;
            ACT_QUERY: res_outcome_nxt = OUT_QUERY;
            ACT_CLEAR: begin
              res_outcome_nxt = OUT_CLEARED;
              clr_nxt         = '0;
              clr_report_nxt  = 1'b1;
              free_nxt        = '1;
            end
            default:   res_outcome_nxt = res_outcome_r;
          endcase
        end
      end
      ST_EV_RD: begin
      end
      ST_EV_DEC: begin
        if (held_rd_r != '0) begin
          held_we         = 1'b1;
          res_outcome_nxt = OUT_RELEASED;
          if (held_rd_r <= MAX_SLOTS_S) begin
            free_nxt[SIW'(held_rd_r - SW'(1))] = 1'b1;
            res_slot_nxt                        = held_rd_r;
          end
        end
      end
      ST_SCAN: begin
        priority if (scan_done) begin
          held_we         = 1'b1;
          held_wdata      = OVF_MARK;
          res_outcome_nxt = OUT_OVERFLOWED;
        end else if (scan_hit) begin
          free_nxt[scan_r[SIW-1:0]] = 1'b0;
          held_we                   = 1'b1;
          held_wdata                = scan_r + SW'(1);
          res_outcome_nxt           = OUT_ALLOCATED;
          res_slot_nxt              = scan_r + SW'(1);
        end else begin
          scan_nxt = scan_r + SW'(1);
        end
      end
      ST_ALLOC_WR: begin
        usage_we    = 1'b1;
        usage_wdata = (usage_rd_r == COUNT_MAX) ? usage_rd_r : usage_rd_r + COUNT_W'(1);
      end
      ST_Q_RD: begin
      end
      ST_Q_ACC: begin
        sum_nxt  = (sum_wide > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum_wide[COUNT_W-1:0];
        scan_nxt = scan_r + SW'(1);
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_outcome_nxt = res_outcome_r;
          out_slot_nxt    = SLOT_W'(res_slot_r);
          out_count_nxt   = (res_outcome_r == OUT_QUERY) ? sum_r : '0;
          clr_report_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      slots_in_use_r <= SLOTS_IN_USE_RST;
      free_r         <= '1;
      clr_r          <= '0;
      clr_report_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      slots_in_use_r <= slots_in_use_nxt;
      free_r         <= free_nxt;
      clr_r          <= clr_nxt;
      clr_report_r   <= clr_report_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r          <= id_nxt;
    scan_r        <= scan_nxt;
    lim_r         <= lim_nxt;
    sum_r         <= sum_nxt;
    res_outcome_r <= res_outcome_nxt;
    res_slot_r    <= res_slot_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_slot_r    <= out_slot_nxt;
    out_count_r   <= out_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (held_we) begin
      held_mem[held_waddr] <= held_wdata;
    end
    held_rd_r <= held_mem[id_r];
  end

  always_ff @(posedge clk) begin
    if (usage_we) begin
      usage_mem[usage_waddr] <= usage_wdata;
    end
    usage_rd_r <= usage_mem[scan_r[SIW-1:0]];
  end

  `LFSA_ASSERT_IMP(a_scan_bound, clk, rst_n, state_r == ST_SCAN, scan_r <= limit,
    "Slot scan ran past the slot limit.")
  `LFSA_ASSERT_NEXT(a_busy_after_req, clk, rst_n,
    in_acc && (in_req.action == ACT_EVENT || in_req.action == ACT_QUERY ||
    in_req.action == ACT_CLEAR), !in_req.ready,
    "A request was followed by another before its result.")
  `LFSA_ASSERT_IMP(a_overflow_slot, clk, rst_n,
    out_valid_r && out_outcome_r == OUT_OVERFLOWED, out_slot_r == '0,
    "An overflow result carries a slot.")
  `LFSA_ASSERT_IMP(a_usage_write, clk, rst_n, usage_we,
    state_r == ST_ALLOC_WR || state_r == ST_CLEAR,
    "A usage counter was written outside allocation or clearing.")

endmodule
`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the lowest free slot allocator, with directed and random tests.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lfsa_pkg::*;

  localparam int SLOTS = MAX_SLOTS_DEF;
  localparam int INTERVALS = MAX_INTERVALS_DEF;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [SLOT_W-1:0] OVERFLOW_MARK = SLOT_W'(SLOTS + 1);
  localparam int SETTLE = 300;

  typedef struct packed {
    outcome_t             outcome;
    logic [SLOT_W-1:0]    slot;
    logic [COUNT_W-1:0]   count;
  } slot_result_t;

  logic clk;
  logic rst_n;

  lfsa_in_if  in_req ();
  lfsa_out_if out_res ();
  lfsa_cfg_if cfg_wr ();

  lowest_free_slot_allocator_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .cfg_wr  (cfg_wr)
  );

  logic [CFG_W-1:0]   slot_cap;
  logic [SLOTS-1:0]   free_map;
  logic [SLOT_W-1:0]  holder [INTERVALS];
  logic [COUNT_W-1:0] usage [SLOTS];
  slot_result_t       pending_results [$];
  int                 mismatch_count;
  bit                 steady_input;
  bit                 steady_output;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic void clear_tables();
    free_map = '1;
    for (int i = 0; i < SLOTS; i++) usage[i] = '0;
    for (int i = 0; i < INTERVALS; i++) holder[i] = '0;
  endfunction

  function automatic void predict_request(logic [ACTION_W-1:0] act,
                                          logic [INTERVAL_W-1:0] id,
                                          logic [SLOT_W-1:0] lim);
    slot_result_t res;
    logic [SLOT_W-1:0] held;
    int top;
    int sum;
    bit found;
    res = '0;
    found = 1'b0;
    sum = 0;
    case (act)
      ACT_EVENT: begin
        held = holder[id];
        if (held == '0) begin
          top = (slot_cap > SLOTS) ? SLOTS : int'(slot_cap);
          for (int s = 1; s <= top; s++) begin
            if (!found && free_map[s-1]) begin
              found = 1'b1;
              free_map[s-1] = 1'b0;
              holder[id] = SLOT_W'(s);
              if (usage[s-1] != COUNT_MAX) usage[s-1] = usage[s-1] + COUNT_W'(1);
              res.outcome = OUT_ALLOCATED;
              res.slot = SLOT_W'(s);
            end
          end
          if (!found) begin
            holder[id] = OVERFLOW_MARK;
            res.outcome = OUT_OVERFLOWED;
          end
        end else begin
          holder[id] = '0;
          res.outcome = OUT_RELEASED;
          if (held <= SLOTS) begin
            free_map[held-1] = 1'b1;
            res.slot = held;
          end
        end
        pending_results.push_back(res);
      end
      ACT_QUERY: begin
        top = (lim > SLOTS) ? SLOTS : int'(lim);
        for (int s = 0; s < top; s++) begin
          sum += usage[s];
          if (sum > COUNT_MAX) sum = COUNT_MAX;
        end
        res.outcome = OUT_QUERY;
        res.count = COUNT_W'(sum);
        pending_results.push_back(res);
      end
      ACT_CLEAR: begin
        clear_tables();
        res.outcome = OUT_CLEARED;
        pending_results.push_back(res);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && cfg_wr.valid && cfg_wr.ready) slot_cap = cfg_wr.data;
    if (rst_n && in_req.valid && in_req.ready)
      predict_request(in_req.action, in_req.interval_id, in_req.slot_limit);
  end

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatch_count++;
    $display("MISMATCH at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    slot_result_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request waiting", 16'(out_res.outcome), 16'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_res.outcome !== want.outcome)
          report_mismatch("outcome", 16'(out_res.outcome), 16'(want.outcome));
        if (out_res.slot !== want.slot)
          report_mismatch("slot", 16'(out_res.slot), 16'(want.slot));
        if (out_res.served_count !== want.count)
          report_mismatch("served_count", 16'(out_res.served_count), 16'(want.count));
      end
    end
  end

  initial begin
    int stall;
    int r;
    stall = 0;
    out_res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_res.ready <= 1'b0;
      end else if (steady_output) begin
        out_res.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_res.ready <= 1'b1;
        end else begin
          stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
          out_res.ready <= 1'b0;
        end
      end
    end
  end

  function automatic int request_gap();
    int r;
    if (steady_input) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_request(logic [ACTION_W-1:0] act, logic [INTERVAL_W-1:0] id,
                              logic [SLOT_W-1:0] lim);
    int gap;
    gap = request_gap();
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.valid       <= 1'b1;
    in_req.action      <= act;
    in_req.interval_id <= id;
    in_req.slot_limit  <= lim;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_event(logic [INTERVAL_W-1:0] id);
    send_request(ACT_EVENT, id, SLOT_W'($urandom));
  endtask

  task automatic send_query(logic [SLOT_W-1:0] lim);
    send_request(ACT_QUERY, INTERVAL_W'($urandom), lim);
  endtask

  task automatic send_clear();
    send_request(ACT_CLEAR, INTERVAL_W'($urandom), SLOT_W'($urandom));
  endtask

  task automatic drain_requests();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // A request with an unused action gives no result, so wait out the longest operation too.
  task automatic write_slot_cap(logic [CFG_W-1:0] value);
    drain_requests();
    repeat (SETTLE) @(negedge clk);
    cfg_wr.valid <= 1'b1;
    cfg_wr.data  <= value;
    @(posedge clk);
    while (!cfg_wr.ready) @(posedge clk);
    @(negedge clk);
    cfg_wr.valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_event(8'd0);
    send_event(8'd255);
    send_query(7'd0);
    send_query(7'd1);
    send_query(7'd127);
    send_event(8'd0);
    send_event(8'd7);
    send_clear();
    send_query(7'd64);
  endtask

  task automatic test_no_slots();
    write_slot_cap(7'd0);
    send_event(8'd5);
    send_event(8'd5);
    send_event(8'd5);
    send_clear();
    send_event(8'd5);
    send_query(7'd64);
  endtask

  task automatic test_full_table();
    write_slot_cap(7'd127);
    send_clear();
    for (int i = 0; i <= SLOTS; i++) send_event(INTERVAL_W'(i));
    send_query(7'd64);
    send_query(7'd65);
    send_event(8'd64);
    send_event(8'd10);
    send_event(8'd200);
    send_clear();
  endtask

  task automatic test_limit_lowered();
    write_slot_cap(7'd64);
    for (int i = 0; i < 4; i++) send_event(INTERVAL_W'(i));
    write_slot_cap(7'd2);
    send_event(8'd2);
    send_event(8'd20);
    send_event(8'd1);
    send_event(8'd21);
    write_slot_cap(7'd64);
    send_event(8'd22);
    send_clear();
  endtask

  task automatic test_unused_action();
    send_request(ACT_UNUSED, INTERVAL_W'($urandom), SLOT_W'($urandom));
    send_query(7'd3);
    send_request(ACT_UNUSED, 8'hff, 7'h7f);
    send_event(8'd9);
  endtask

  task automatic test_count_saturation();
    steady_input = 1'b1;
    steady_output = 1'b1;
    write_slot_cap(7'd1);
    send_clear();
    repeat (512) begin
      send_event(8'd10);
      send_event(8'd10);
    end
    write_slot_cap(7'd2);
    send_event(8'd10);
    send_event(8'd11);
    send_query(7'd1);
    send_query(7'd2);
    send_query(7'd127);
    send_clear();
    steady_input = 1'b0;
    steady_output = 1'b0;
  endtask

  task automatic test_random_traffic();
    int caps [6];
    int pools [6];
    int r;
    caps = '{3, 64, 0, 127, 0, 0};
    pools = '{8, 24, 4, 128, 16, 40};
    caps[4] = $urandom_range(1, 10);
    caps[5] = $urandom_range(0, 127);
    for (int phase = 0; phase < 6; phase++) begin
      write_slot_cap(CFG_W'(caps[phase]));
      steady_input = (phase == 1);
      steady_output = (phase == 3);
      repeat (105) begin
        if ($urandom_range(0, 99) < 2) drain_requests();
        r = $urandom_range(0, 99);
        if (r < 70)
          send_event(INTERVAL_W'($urandom_range(0, pools[phase] - 1)));
        else if (r < 86)
          send_query($urandom_range(0, 1) ? SLOT_W'($urandom_range(0, 127))
                                          : SLOT_W'($urandom_range(0, 8)));
        else if (r < 89)
          send_clear();
        else if (r < 92)
          send_request(ACT_UNUSED, INTERVAL_W'($urandom), SLOT_W'($urandom));
        else
          send_event(INTERVAL_W'($urandom));
      end
    end
    steady_input = 1'b0;
    steady_output = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_req.valid = 1'b0;
    in_req.action = ACT_EVENT;
    in_req.interval_id = '0;
    in_req.slot_limit = '0;
    cfg_wr.valid = 1'b0;
    cfg_wr.data = '0;
    steady_input = 1'b0;
    steady_output = 1'b0;
    mismatch_count = 0;
    slot_cap = SLOTS_IN_USE_RST;
    clear_tables();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_no_slots();
    test_full_table();
    test_limit_lowered();
    test_unused_action();
    test_count_saturation();
    test_random_traffic();
    drain_requests();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

[lowest_free_slot_allocator_top.f]
+incdir+hw/rtl
hw/rtl/lfsa_pkg.sv
hw/rtl/lfsa_if.sv
hw/rtl/lowest_free_slot_allocator_top.sv
dv/tb.sv
